### rtl/receive_window_dedup_unit_macros.svh
// Assertion helpers shared by the receive window RTL.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef RECEIVE_WINDOW_DEDUP_UNIT_MACROS_SVH
`define RECEIVE_WINDOW_DEDUP_UNIT_MACROS_SVH

// Same-cycle implication.
`define RWD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("receive window check failed");

// Next-cycle implication.
`define RWD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("receive window check failed");

`endif

### rtl/rwd_pkg.sv
`timescale 1ns / 1ps

package rwd_pkg;

  localparam int unsigned SENDER_W  = 4;
  localparam int unsigned SEQ_W     = 64;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned TDATA_W   = 72;

  // Packet classification
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_STALE    = 3'd0,
    VERDICT_IN_ORDER = 3'd1,
    VERDICT_NEW      = 3'd2,
    VERDICT_DUP      = 3'd3,
    VERDICT_BEYOND   = 3'd4
  } rwd_verdict_e;

  // Queue entry handed from the front end to the back end
  typedef struct packed {
    logic                oor;
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq;
  } rwd_item_t;

  // Result held in the output register
  typedef struct packed {
    logic [SEQ_W-1:0] expected_after;
    logic             send_ack;
    logic             deliver;
    rwd_verdict_e     verdict;
  } rwd_result_t;

endpackage

### rtl/rwd_ram.sv
`timescale 1ns / 1ps

module rwd_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/rwd_front.sv
`timescale 1ns / 1ps

`include "receive_window_dedup_unit_macros.svh"

module rwd_front import rwd_pkg::*; #(
  parameter int unsigned NUM_SENDERS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SENDER_W-1:0] in_sender_i,
  input  logic [SEQ_W-1:0]    in_seq_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output rwd_item_t           q_item_o
);

  localparam logic [8:0] NumSendersW = 9'(NUM_SENDERS);

  rwd_item_t   entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;
  rwd_item_t   push_item;

  // Classify the request: flag senders with no window
  always_comb begin
    push_item.oor    = (9'(in_sender_i) >= NumSendersW);
    push_item.sender = in_sender_i;
    push_item.seq    = in_seq_i;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item;
    end
  end

  `RWD_ASSERT_IMP(a_fill_bounded, 1'b1, count_q != 2'd3)
  `RWD_ASSERT_NXT(a_push_only_fills, push && !pop, count_q != 2'd0)
  `RWD_ASSERT_IMP(a_ptrs_agree, count_q == 2'd0 || count_q == 2'd2, wr_ptr_q == rd_ptr_q)

endmodule

### rtl/rwd_back.sv
`timescale 1ns / 1ps

`include "receive_window_dedup_unit_macros.svh"

module rwd_back import rwd_pkg::*; #(
  parameter int unsigned NUM_SENDERS = 16,
  parameter int unsigned WINDOW      = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  rwd_item_t   q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rwd_result_t out_result_o
);

  localparam int unsigned AW = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int unsigned BW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned RW = SEQ_W + WINDOW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CALC   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [NUM_SENDERS-1:0] valid_q;
  rwd_item_t              item_q;
  logic [SEQ_W-1:0]       exp_q;
  logic [WINDOW-1:0]      map_q;
  rwd_verdict_e           verdict_q;
  logic [CW-1:0]          ones_q;
  logic [BW-1:0]          bit_q;
  logic                   out_valid_q;
  rwd_result_t            out_q;

  logic [7:0]             q_sender_ext, item_sender_ext;
  logic [AW-1:0]          q_addr, item_addr;
  logic                   pop, ram_re, ram_we, fire;
  logic [RW-1:0]          ram_rdata, ram_wdata;

  logic [SEQ_W-1:0]       cur_exp, diff, diff_m1;
  logic [WINDOW-1:0]      cur_map;
  logic                   is_lt, is_zero, in_win;
  rwd_verdict_e           verdict_c;
  logic [CW-1:0]          ones_c;

  logic [SEQ_W-1:0]       new_exp;
  logic [WINDOW-1:0]      new_map;
  logic                   deliver_c, ack_c;

  // Count trailing ones of the window bitmap
  function automatic logic [CW-1:0] trailing_ones(input logic [WINDOW-1:0] v);
    logic [CW-1:0] n;
    n = CW'(WINDOW);
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!v[i]) begin
        n = CW'(i);
      end
    end
    return n;
  endfunction

  assign q_sender_ext    = 8'(q_item_i.sender);
  assign item_sender_ext = 8'(item_q.sender);
  assign q_addr          = q_sender_ext[AW-1:0];
  assign item_addr       = item_sender_ext[AW-1:0];

  assign q_ready_o = (state_q == ST_IDLE);
  assign pop       = q_valid_i & q_ready_o;
  assign ram_re    = pop & ~q_item_i.oor;
  assign fire      = (state_q == ST_FINISH) & (~out_valid_q | out_ready_i);
  assign ram_we    = fire & ~item_q.oor;

  // Per-sender window state, read in the cycle before classification
  rwd_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_SENDERS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_addr),
    .rdata_o (ram_rdata)
  );

  // Classify against the expected number; unwritten entries read as reset state
  always_comb begin
    cur_exp = valid_q[item_addr] ? ram_rdata[SEQ_W-1:0] : SEQ_W'(1);
    cur_map = valid_q[item_addr] ? ram_rdata[RW-1:SEQ_W] : '0;
    is_lt   = (item_q.seq < cur_exp);
    diff    = item_q.seq - cur_exp;
    diff_m1 = item_q.seq + ~cur_exp;
    is_zero = (diff == '0);
    in_win  = (diff <= SEQ_W'(WINDOW));
    ones_c  = trailing_ones(cur_map);
    if (is_lt) begin
      verdict_c = VERDICT_STALE;
    end else if (is_zero) begin
      verdict_c = VERDICT_IN_ORDER;
    end else if (in_win) begin
      verdict_c = cur_map[diff_m1[BW-1:0]] ? VERDICT_DUP : VERDICT_NEW;
    end else begin
      verdict_c = VERDICT_BEYOND;
    end
  end

  // Update the window and form the result
  always_comb begin
    new_exp   = exp_q;
    new_map   = map_q;
    deliver_c = 1'b0;
    ack_c     = 1'b1;
    case (verdict_q) inside
      VERDICT_IN_ORDER: begin
        new_exp   = exp_q + SEQ_W'(ones_q) + SEQ_W'(1);
        new_map   = (map_q >> 1) >> ones_q;
        deliver_c = 1'b1;
      end
      VERDICT_NEW: begin
        new_map   = map_q | (WINDOW'(1) << bit_q);
        deliver_c = 1'b1;
      end
      VERDICT_STALE, VERDICT_DUP: begin
        ack_c = 1'b1;
      end
      default: begin
        ack_c = 1'b0;
      end
    endcase
    if (item_q.oor) begin
      deliver_c = 1'b0;
      ack_c     = 1'b0;
    end
  end

  assign ram_wdata = {new_map, new_exp};

  // Sequence one request through read, classify and update
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          state_d = q_item_i.oor ? ST_FINISH : ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[item_addr] <= 1'b1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request, the classification and the result
  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q    <= q_item_i;
      verdict_q <= VERDICT_BEYOND;
    end
    if (state_q == ST_CALC) begin
      exp_q     <= cur_exp;
      map_q     <= cur_map;
      verdict_q <= verdict_c;
      ones_q    <= ones_c;
      bit_q     <= diff_m1[BW-1:0];
    end
    if (fire) begin
      out_q.verdict        <= item_q.oor ? VERDICT_BEYOND : verdict_q;
      out_q.deliver        <= deliver_c;
      out_q.send_ack       <= ack_c;
      out_q.expected_after <= item_q.oor ? '0 : new_exp;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  `RWD_ASSERT_NXT(a_write_then_idle, ram_we, state_q == ST_IDLE)
  `RWD_ASSERT_IMP(a_write_in_finish, ram_we, state_q == ST_FINISH && !item_q.oor)
  `RWD_ASSERT_NXT(a_read_then_calc, ram_re, state_q == ST_CALC)

endmodule

### rtl/receive_window_dedup_unit.sv
`timescale 1ns / 1ps

// Per-sender receive window with duplicate detection. Each request on the slave
// side is a packet header (sender, sequence number); each gives exactly one result
// on the master side: verdict, deliver, send_ack and the sender's next expected
// number. A two-entry queue decouples the input from the window engine, so new
// headers are taken while a result waits. The engine handles one header at a time,
// stepping through state memory read, classify, and update and write back; a
// header from a sender at or above NUM_SENDERS skips the read and classify
// steps. Window state lives in a single-port-write memory of NUM_SENDERS
// entries; per-entry valid flags give reset values, so no clearing pass is
// needed and the block accepts requests straight after reset.

module receive_window_dedup_unit import rwd_pkg::*; #(
  parameter int unsigned NUM_SENDERS = 16,
  parameter int unsigned WINDOW      = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [3:0] sender_index, [67:4] seq_number, [71:68] zero
  input  logic [TDATA_W-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [2:0] verdict, [3] deliver, [4] send_ack, [68:5] expected_after, [71:69] zero
  output logic [TDATA_W-1:0] m_axis_tdata
);

  logic        q_valid, q_ready;
  rwd_item_t   q_item;
  rwd_result_t result;

  rwd_front #(
    .NUM_SENDERS (NUM_SENDERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sender_i (s_axis_tdata[SENDER_W-1:0]),
    .in_seq_i    (s_axis_tdata[SENDER_W+SEQ_W-1:SENDER_W]),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  rwd_back #(
    .NUM_SENDERS (NUM_SENDERS),
    .WINDOW      (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_item_i     (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

  // Pack the result, verdict in the lowest bits
  assign m_axis_tdata = TDATA_W'(result);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rwd_pkg::*;

  localparam int unsigned NUM_SENDERS   = 16;
  localparam int unsigned WINDOW        = 64;
  localparam int unsigned DIRECTED_ROWS = 24;
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam int unsigned MAX_GAP       = 13;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned VERDICT_KINDS = 5;
  localparam logic [SEQ_W-1:0] SEQ_MAX  = '1;

  // One row of the directed table; the result fields count only when typed is set
  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq;
    logic                typed;
    rwd_verdict_e        verdict;
    logic                deliver;
    logic                send_ack;
    logic [SEQ_W-1:0]    expected_after;
  } directed_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;

  // Window state mirrored per sender
  logic [SEQ_W-1:0] win_next [NUM_SENDERS];
  logic [WINDOW-1:0] win_seen [NUM_SENDERS];

  rwd_result_t pending_results [$];

  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned directed_sent  = 0;
  int unsigned random_sent    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned verdict_seen [VERDICT_KINDS];
  bit          tx_calm        = 1'b0;
  bit          rx_calm        = 1'b0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // fresh sender: in order, then the same packet again is stale
    '{4'd0,  64'd1,   1'b1, VERDICT_IN_ORDER, 1'b1, 1'b1, 64'd2},
    '{4'd0,  64'd1,   1'b1, VERDICT_STALE,    1'b0, 1'b1, 64'd2},
    '{4'd1,  64'd0,   1'b1, VERDICT_STALE,    1'b0, 1'b1, 64'd1},
    // top sender: far beyond, just past the window, top and bottom window slots
    '{4'd15, SEQ_MAX, 1'b1, VERDICT_BEYOND,   1'b0, 1'b0, 64'd1},
    '{4'd15, 64'd66,  1'b1, VERDICT_BEYOND,   1'b0, 1'b0, 64'd1},
    '{4'd15, 64'd65,  1'b1, VERDICT_NEW,      1'b1, 1'b1, 64'd1},
    '{4'd15, 64'd65,  1'b1, VERDICT_DUP,      1'b0, 1'b1, 64'd1},
    '{4'd15, 64'd2,   1'b1, VERDICT_NEW,      1'b1, 1'b1, 64'd1},
    // out-of-order run, then a gap closed so the window jumps past it
    '{4'd2,  64'd3,   1'b1, VERDICT_NEW,      1'b1, 1'b1, 64'd1},
    '{4'd2,  64'd4,   1'b1, VERDICT_NEW,      1'b1, 1'b1, 64'd1},
    '{4'd2,  64'd5,   1'b1, VERDICT_NEW,      1'b1, 1'b1, 64'd1},
    '{4'd2,  64'd4,   1'b1, VERDICT_DUP,      1'b0, 1'b1, 64'd1},
    '{4'd2,  64'd1,   1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    '{4'd2,  64'd2,   1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    '{4'd2,  64'd6,   1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    '{4'd2,  64'd4,   1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    // top sender advances by two and keeps its far mark
    '{4'd15, 64'd1,   1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    '{4'd15, 64'd67,  1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    '{4'd15, 64'd68,  1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    '{4'd15, 64'd65,  1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0},
    // alternating bit patterns and the top bit of the sequence number
    '{4'd7,  64'h8000_0000_0000_0000, 1'b0, VERDICT_STALE, 1'b0, 1'b0, 64'd0},
    '{4'd8,  64'h5555_5555_5555_5555, 1'b0, VERDICT_STALE, 1'b0, 1'b0, 64'd0},
    '{4'd9,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, VERDICT_STALE, 1'b0, 1'b0, 64'd0},
    '{4'd0,  64'd0,   1'b0, VERDICT_STALE,    1'b0, 1'b0, 64'd0}
  };

  receive_window_dedup_unit #(
    .NUM_SENDERS(NUM_SENDERS),
    .WINDOW     (WINDOW)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Classify one header against the mirrored window and advance that window
  function automatic rwd_result_t classify_header(input logic [SENDER_W-1:0] sender,
                                                  input logic [SEQ_W-1:0] seq);
    rwd_result_t       res;
    logic [SEQ_W-1:0]  next_seq;
    logic [SEQ_W-1:0]  ahead;
    logic [WINDOW-1:0] seen;
    int unsigned       run;
    next_seq     = win_next[sender];
    seen         = win_seen[sender];
    res.verdict  = VERDICT_BEYOND;
    res.deliver  = 1'b0;
    res.send_ack = 1'b0;
    if (seq < next_seq) begin
      res.verdict  = VERDICT_STALE;
      res.send_ack = 1'b1;
    end else begin
      ahead = seq - next_seq;
      if (ahead == '0) begin
        // skip this packet and every contiguous one already marked
        run = 0;
        while (run < WINDOW && seen[run]) run++;
        res.verdict  = VERDICT_IN_ORDER;
        res.deliver  = 1'b1;
        res.send_ack = 1'b1;
        next_seq     = next_seq + SEQ_W'(run + 1);
        seen         = (run + 1 >= WINDOW) ? '0 : seen >> (run + 1);
      end else if (ahead <= WINDOW) begin
        res.send_ack = 1'b1;
        if (seen[ahead - 1]) begin
          res.verdict = VERDICT_DUP;
        end else begin
          res.verdict     = VERDICT_NEW;
          res.deliver     = 1'b1;
          seen[ahead - 1] = 1'b1;
        end
      end
    end
    win_next[sender]   = next_seq;
    win_seen[sender]   = seen;
    res.expected_after = next_seq;
    return res;
  endfunction

  // Mostly headers near the current window, some stale, beyond or fully random
  function automatic logic [SEQ_W-1:0] pick_seq_near(input logic [SEQ_W-1:0] base);
    int unsigned      roll;
    int unsigned      back;
    logic [SEQ_W-1:0] seq;
    roll = $urandom_range(0, 99);
    back = $urandom_range(1, 8);
    if (roll < 30) begin
      seq = base;
    end else if (roll < 70) begin
      seq = base + SEQ_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? WINDOW : 8));
    end else if (roll < 80) begin
      seq = (base > back) ? base - back : '0;
    end else if (roll < 90) begin
      seq = base + SEQ_W'(WINDOW + 1 + $urandom_range(0, 200));
    end else begin
      seq = {$urandom, $urandom};
    end
    return seq;
  endfunction

  function automatic int unsigned draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Offer one request, hold it until taken, then record what it must give
  task automatic send_header(input logic [SENDER_W-1:0] sender, input logic [SEQ_W-1:0] seq,
                             input logic typed, input rwd_result_t typed_res);
    int unsigned gap;
    rwd_result_t predicted;
    gap = draw_gap(tx_calm);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W - SEQ_W - SENDER_W){1'b0}}, seq, sender};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = classify_header(sender, seq);
    verdict_seen[predicted.verdict]++;
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Check each result against the oldest outstanding one
  always @(posedge clk_i) begin
    rwd_result_t got;
    rwd_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got = rwd_result_t'(m_axis_tdata[$bits(rwd_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: verdict %0d deliver %0b ack %0b next %0d",
                   $realtime, got.verdict, got.deliver, got.send_ack, got.expected_after);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.verdict !== want.verdict || got.deliver !== want.deliver ||
            got.send_ack !== want.send_ack || got.expected_after !== want.expected_after) begin
          if (mismatches < 10)
            $display("[%0t] result %0d: want %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
                     $realtime, results_seen, want.verdict, want.deliver, want.send_ack,
                     want.expected_after, got.verdict, got.deliver, got.send_ack,
                     got.expected_after);
          mismatches++;
        end
      end
    end
  end

  // Abort when neither side moves a request for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned gap;
    bit          held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = draw_gap(rx_calm);
      end
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Request side: reset, directed table, then random traffic
  initial begin
    rwd_result_t          typed_res;
    logic [SENDER_W-1:0]  sender;
    logic [SEQ_W-1:0]     base;
    int unsigned          offsets [WINDOW];
    int unsigned          next_fill;
    int unsigned          pick;
    int unsigned          swap;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    for (int k = 0; k < NUM_SENDERS; k++) begin
      win_next[k] = SEQ_W'(1);
      win_seen[k] = '0;
    end
    for (int k = 0; k < VERDICT_KINDS; k++) verdict_seen[k] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      typed_res.verdict        = directed_rows[r].verdict;
      typed_res.deliver        = directed_rows[r].deliver;
      typed_res.send_ack       = directed_rows[r].send_ack;
      typed_res.expected_after = directed_rows[r].expected_after;
      send_header(directed_rows[r].sender, directed_rows[r].seq, directed_rows[r].typed,
                  typed_res);
      directed_sent++;
    end

    // Random traffic, mostly on a few senders so their windows get deep
    next_fill = 200;
    while (random_sent < RANDOM_ITEMS) begin
      sender = ($urandom_range(0, 3) == 0) ? SENDER_W'($urandom_range(0, NUM_SENDERS - 1))
                                          : SENDER_W'($urandom_range(0, 3));
      if (random_sent >= next_fill) begin
        // fill the whole window in shuffled order, then close it with one in-order packet
        next_fill += 250;
        base = win_next[sender];
        for (int k = 0; k < WINDOW; k++) offsets[k] = k + 1;
        for (int k = WINDOW - 1; k > 0; k--) begin
          pick         = $urandom_range(0, k);
          swap         = offsets[k];
          offsets[k]   = offsets[pick];
          offsets[pick] = swap;
        end
        for (int k = 0; k < WINDOW; k++)
          send_header(sender, base + SEQ_W'(offsets[k]), 1'b0, typed_res);
        send_header(sender, base, 1'b0, typed_res);
        random_sent += WINDOW + 1;
      end else begin
        send_header(sender, pick_seq_near(win_next[sender]), 1'b0, typed_res);
        random_sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the pipeline to settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d directed and %0d random headers, %0d results checked, %0d mismatches",
             directed_sent, random_sent, results_seen, mismatches);
    $display("Verdicts: stale %0d, in order %0d, new %0d, duplicate %0d, beyond %0d",
             verdict_seen[VERDICT_STALE], verdict_seen[VERDICT_IN_ORDER],
             verdict_seen[VERDICT_NEW], verdict_seen[VERDICT_DUP],
             verdict_seen[VERDICT_BEYOND]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rwd_pkg.sv
rtl/rwd_ram.sv
rtl/rwd_front.sv
rtl/rwd_back.sv
rtl/receive_window_dedup_unit.sv
tb/sv/testbench.sv
